>>> design/ugcd_pkg.sv
// Shared constants for the undirected graph cycle detector.
`timescale 1ns / 1ps
`default_nettype none

package ugcd_pkg;

    localparam int VERTEX_COUNT_DEF = 16;
    localparam int VERTEX_FIELD_W   = 4;

    localparam logic ACT_ADD_EDGE = 1'b0;
    localparam logic ACT_QUERY    = 1'b1;

endpackage

`default_nettype wire

>>> design/undirected_graph_cycle_detector.sv
// Undirected graph cycle detector top level.
//
// Input channel (in_valid / in_stall): one beat carries action, first_vertex
// and second_vertex. Action add-edge sets both adjacency bits for the pair and
// returns nothing; a pair with a vertex at or above VERTEX_COUNT is dropped.
// Action query runs a depth-first search over all components and returns one
// beat on the output channel (out_valid / out_stall) with cycle_found.
// An add-edge beat reads and rewrites the row of each vertex in turn; a dropped
// pair leaves the sequencer idle. A query is paced by the single read port of
// the adjacency row memory: one row read per visited vertex, neighbors scanned
// one at a time and a search-record read per backtrack. The search stops at the
// first non-tree edge back to a seen vertex.
// in_stall is low only between items. A finished result sits in the output
// register while the next beat is accepted; a query completing behind a
// stalled result holds until that beat is taken.
// Reset clears the graph through per-row valid bits at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module undirected_graph_cycle_detector #(
    parameter int VERTEX_COUNT = ugcd_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic [ugcd_pkg::VERTEX_FIELD_W-1:0] first_vertex,
    input  wire logic [ugcd_pkg::VERTEX_FIELD_W-1:0] second_vertex,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     cycle_found
);
    import ugcd_pkg::*;

    localparam int VW     = $clog2(VERTEX_COUNT);
    localparam int WALK_W = VERTEX_COUNT + VW + 1;

    logic                    adj_rd_en;
    logic [VW-1:0]           adj_rd_addr;
    logic                    adj_wr_en;
    logic [VW-1:0]           adj_wr_addr;
    logic [VERTEX_COUNT-1:0] adj_wr_data;
    logic [VERTEX_COUNT-1:0] adj_rd_data;
    logic                    walk_rd_en;
    logic [VW-1:0]           walk_rd_addr;
    logic                    walk_wr_en;
    logic [VW-1:0]           walk_wr_addr;
    logic [WALK_W-1:0]       walk_wr_data;
    logic [WALK_W-1:0]       walk_rd_data;

    ugcd_adj_ram #(
        .DEPTH (VERTEX_COUNT),
        .WIDTH (VERTEX_COUNT)
    ) u_adj_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_data (adj_rd_data)
    );

    ugcd_walk_ram #(
        .DEPTH (VERTEX_COUNT),
        .WIDTH (WALK_W)
    ) u_walk_ram (
        .clk     (clk),
        .rd_en   (walk_rd_en),
        .rd_addr (walk_rd_addr),
        .wr_en   (walk_wr_en),
        .wr_addr (walk_wr_addr),
        .wr_data (walk_wr_data),
        .rd_data (walk_rd_data)
    );

    ugcd_ctrl #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cycle_found   (cycle_found),
        .adj_rd_en     (adj_rd_en),
        .adj_rd_addr   (adj_rd_addr),
        .adj_wr_en     (adj_wr_en),
        .adj_wr_addr   (adj_wr_addr),
        .adj_wr_data   (adj_wr_data),
        .adj_rd_data   (adj_rd_data),
        .walk_rd_en    (walk_rd_en),
        .walk_rd_addr  (walk_rd_addr),
        .walk_wr_en    (walk_wr_en),
        .walk_wr_addr  (walk_wr_addr),
        .walk_wr_data  (walk_wr_data),
        .walk_rd_data  (walk_rd_data)
    );

endmodule

`default_nettype wire

>>> design/ugcd_adj_ram.sv
// Adjacency row memory with per-row valid bits and registered read.
`timescale 1ns / 1ps
`default_nettype none

module ugcd_adj_ram #(
    parameter int DEPTH = ugcd_pkg::VERTEX_COUNT_DEF,
    parameter int WIDTH = ugcd_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    output logic      [WIDTH-1:0]           rd_data
);
    import ugcd_pkg::*;

    logic [WIDTH-1:0] row_mem_reg [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> design/ugcd_walk_ram.sv
// Search record memory: per-vertex pending neighbors and tree parent.
`timescale 1ns / 1ps
`default_nettype none

module ugcd_walk_ram #(
    parameter int DEPTH = ugcd_pkg::VERTEX_COUNT_DEF,
    parameter int WIDTH = ugcd_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    output logic      [WIDTH-1:0]           rd_data
);
    import ugcd_pkg::*;

    logic [WIDTH-1:0] entry_mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/ugcd_ctrl.sv
// Sequencer for edge insertion and depth-first cycle search, with result register.
`timescale 1ns / 1ps
`default_nettype none

module ugcd_ctrl #(
    parameter int VERTEX_COUNT = ugcd_pkg::VERTEX_COUNT_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   action,
    input  wire logic [ugcd_pkg::VERTEX_FIELD_W-1:0]    first_vertex,
    input  wire logic [ugcd_pkg::VERTEX_FIELD_W-1:0]    second_vertex,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        cycle_found,
    output logic                                        adj_rd_en,
    output logic [$clog2(VERTEX_COUNT)-1:0]             adj_rd_addr,
    output logic                                        adj_wr_en,
    output logic [$clog2(VERTEX_COUNT)-1:0]             adj_wr_addr,
    output logic [VERTEX_COUNT-1:0]                     adj_wr_data,
    input  wire logic [VERTEX_COUNT-1:0]                adj_rd_data,
    output logic                                        walk_rd_en,
    output logic [$clog2(VERTEX_COUNT)-1:0]             walk_rd_addr,
    output logic                                        walk_wr_en,
    output logic [$clog2(VERTEX_COUNT)-1:0]             walk_wr_addr,
    output logic [VERTEX_COUNT+$clog2(VERTEX_COUNT):0]  walk_wr_data,
    input  wire logic [VERTEX_COUNT+$clog2(VERTEX_COUNT):0] walk_rd_data
);
    import ugcd_pkg::*;

    localparam int N  = VERTEX_COUNT;
    localparam int VW = $clog2(VERTEX_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_ROOT,
        S_LOAD,
        S_SCAN,
        S_POP,
        S_DONE
    } state_t;

    function automatic logic [VW-1:0] low_idx(input logic [N-1:0] x);
        logic [N-1:0]  iso;
        logic [VW-1:0] idx;
        iso = x & (~x + N'(1));
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (iso[i])
            begin
                idx = idx | VW'(i);
            end
        end
        return idx;
    endfunction

    state_t        state_reg;
    logic [N-1:0]  seen_reg;
    logic [VW-1:0] cur_v_reg;
    logic [VW-1:0] cur_up_reg;
    logic          cur_has_up_reg;
    logic [N-1:0]  cur_todo_reg;
    logic [VW-1:0] edge_a_reg;
    logic [VW-1:0] edge_b_reg;
    logic          found_reg;
    logic          out_valid_reg;
    logic          cycle_found_reg;

    logic          in_fire;
    logic          in_range;
    logic [VW-1:0] low_u;
    logic [N-1:0]  bit_u;
    logic [N-1:0]  todo_left;
    logic          u_seen;
    logic          is_parent;
    logic [VW-1:0] root_idx;
    logic          all_seen;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign in_range  = (32'(first_vertex) < 32'(N)) && (32'(second_vertex) < 32'(N));
    assign low_u     = low_idx(cur_todo_reg);
    assign bit_u     = N'(1) << low_u;
    assign todo_left = cur_todo_reg & ~bit_u;
    assign u_seen    = seen_reg[low_u];
    assign is_parent = cur_has_up_reg && (cur_up_reg == low_u);
    assign root_idx  = low_idx(~seen_reg);
    assign all_seen  = &seen_reg;

    assign out_valid   = out_valid_reg;
    assign cycle_found = cycle_found_reg;

    always_comb
    begin
        adj_rd_en    = 1'b0;
        adj_rd_addr  = '0;
        adj_wr_en    = 1'b0;
        adj_wr_addr  = '0;
        adj_wr_data  = '0;
        walk_rd_en   = 1'b0;
        walk_rd_addr = cur_up_reg;
        walk_wr_en   = 1'b0;
        walk_wr_addr = cur_v_reg;
        walk_wr_data = {cur_has_up_reg, cur_up_reg, todo_left};
        case (state_reg)
            S_IDLE:
            begin
                adj_rd_en   = in_fire && (action == ACT_ADD_EDGE) && in_range;
                adj_rd_addr = VW'(first_vertex);
            end
            S_EDGE_A:
            begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = edge_b_reg;
                adj_wr_en   = 1'b1;
                adj_wr_addr = edge_a_reg;
                adj_wr_data = adj_rd_data | (N'(1) << edge_b_reg);
            end
            S_EDGE_B:
            begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = edge_b_reg;
                adj_wr_data = adj_rd_data | (N'(1) << edge_a_reg);
            end
            S_ROOT:
            begin
                adj_rd_en   = !all_seen;
                adj_rd_addr = root_idx;
            end
            S_SCAN:
            begin
                if (cur_todo_reg != '0)
                begin
                    adj_rd_en   = !u_seen;
                    adj_rd_addr = low_u;
                    walk_wr_en  = !u_seen;
                end
                else
                begin
                    walk_rd_en = cur_has_up_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seen_reg        <= '0;
            cur_v_reg       <= '0;
            cur_up_reg      <= '0;
            cur_has_up_reg  <= 1'b0;
            cur_todo_reg    <= '0;
            edge_a_reg      <= '0;
            edge_b_reg      <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            cycle_found_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (action == ACT_QUERY)
                        begin
                            seen_reg  <= '0;
                            state_reg <= S_ROOT;
                        end
                        else if (in_range)
                        begin
                            edge_a_reg <= VW'(first_vertex);
                            edge_b_reg <= VW'(second_vertex);
                            state_reg  <= S_EDGE_A;
                        end
                    end
                end
                S_EDGE_A:
                begin
                    state_reg <= S_EDGE_B;
                end
                S_EDGE_B:
                begin
                    state_reg <= S_IDLE;
                end
                S_ROOT:
                begin
                    if (all_seen)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        seen_reg       <= seen_reg | (N'(1) << root_idx);
                        cur_v_reg      <= root_idx;
                        cur_up_reg     <= '0;
                        cur_has_up_reg <= 1'b0;
                        state_reg      <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    cur_todo_reg <= adj_rd_data;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (cur_todo_reg == '0)
                    begin
                        if (cur_has_up_reg)
                        begin
                            cur_v_reg <= cur_up_reg;
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            state_reg <= S_ROOT;
                        end
                    end
                    else if (!u_seen)
                    begin
                        seen_reg       <= seen_reg | bit_u;
                        cur_up_reg     <= cur_v_reg;
                        cur_has_up_reg <= 1'b1;
                        cur_v_reg      <= low_u;
                        state_reg      <= S_LOAD;
                    end
                    else if (!is_parent)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_todo_reg <= todo_left;
                    end
                end
                S_POP:
                begin
                    {cur_has_up_reg, cur_up_reg, cur_todo_reg} <= walk_rd_data;
                    state_reg <= S_SCAN;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        cycle_found_reg <= found_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cur_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> seen_reg[cur_v_reg])
        else $error("current vertex not marked seen");

    a_parent_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cur_has_up_reg) |-> seen_reg[cur_up_reg])
        else $error("tree parent not marked seen");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == ACT_QUERY) |=> (state_reg == S_ROOT))
        else $error("query beat did not start a search");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat without a finished search");
`endif

endmodule

`default_nettype wire
